>>> rtl/lexbuf_pkg.sv
package lexbuf_pkg;

  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CHAR_W    = 8;
  localparam int COUNT_W   = 16;
  localparam int ACTION_W  = 3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_APPEND  = 3'd0,
    ACT_READ    = 3'd1,
    ACT_MARK    = 3'd2,
    ACT_RETRACT = 3'd3,
    ACT_RESTORE = 3'd4,
    ACT_REWIND  = 3'd5,
    ACT_CLEAR   = 3'd6,
    ACT_QUERY   = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    GROW_FIXED = 2'd0,
    GROW_ADD   = 2'd1,
    GROW_MUL   = 2'd2
  } growth_t;

  localparam logic [CFG_IDX_W-1:0] REG_GROWTH_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_CAP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GROWTH_INC  = 2'd2;

  localparam logic [1:0]       RESET_GROWTH_MODE = 2'd0;
  localparam logic [CFG_W-1:0] RESET_INIT_CAP    = 13'd256;
  localparam logic [CFG_W-1:0] RESET_GROWTH_INC  = 13'd16;

  // per-transaction status passed from the pointer logic to the result stage
  typedef struct packed {
    logic ok;
    logic end_seen;
    logic grew;
    logic full;
    logic empty;
    logic byte_rd;
    logic cnt_bump;
    logic cnt_query;
  } stat_t;

endpackage

>>> rtl/lexbuf_in_if.sv
interface lexbuf_in_if #(
  parameter int PW = 13
);
  logic                                valid;
  logic                                ready;
  logic [lexbuf_pkg::ACTION_W-1:0]     action;
  logic [lexbuf_pkg::CHAR_W-1:0]       char_value;
  logic [PW-1:0]                       mark_target;

  modport source (output valid, action, char_value, mark_target, input ready);
  modport sink   (input valid, action, char_value, mark_target, output ready);
endinterface

>>> rtl/lexbuf_out_if.sv
interface lexbuf_out_if #(
  parameter int PW = 13
);
  logic                               valid;
  logic                               ready;
  logic                               ok;
  logic [lexbuf_pkg::CHAR_W-1:0]      char_out;
  logic                               end_of_data;
  logic                               grew;
  logic                               full_res;
  logic                               empty_res;
  logic [PW-1:0]                      read_position;
  logic [PW-1:0]                      write_position;
  logic [PW-1:0]                      mark_position;
  logic [PW-1:0]                      capacity_now;
  logic [lexbuf_pkg::COUNT_W-1:0]     symbol_count;

  modport source (
    output valid, ok, char_out, end_of_data, grew, full_res, empty_res,
           read_position, write_position, mark_position, capacity_now, symbol_count,
    input  ready
  );
  modport sink (
    input  valid, ok, char_out, end_of_data, grew, full_res, empty_res,
           read_position, write_position, mark_position, capacity_now, symbol_count,
    output ready
  );
endinterface

>>> rtl/lexbuf_cfg_if.sv
interface lexbuf_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [lexbuf_pkg::CFG_IDX_W-1:0]    index;
  logic [lexbuf_pkg::CFG_W-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/lexbuf_ram.sv
module lexbuf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/lexbuf_ctrl.sv
module lexbuf_ctrl #(
  parameter int STORE_DEPTH = 4096,
  parameter int COUNTED_SYMBOLS = 128,
  localparam int PW = $clog2(STORE_DEPTH + 1),
  localparam int AW = $clog2(STORE_DEPTH)
) (
  input  logic                            clk,
  input  logic                            rst,
  lexbuf_cfg_if.sink                      cfg,
  input  logic                            accept,
  input  logic [lexbuf_pkg::ACTION_W-1:0] action,
  input  logic [lexbuf_pkg::CHAR_W-1:0]   ch,
  input  logic [PW-1:0]                   target,
  output lexbuf_pkg::stat_t               st,
  output logic [PW-1:0]                   rd_next,
  output logic [PW-1:0]                   wr_next,
  output logic [PW-1:0]                   mark_next,
  output logic [PW-1:0]                   cap_next,
  output logic                            mem_we,
  output logic [AW-1:0]                   mem_waddr,
  output logic [AW-1:0]                   mem_raddr
);

  localparam int CW   = lexbuf_pkg::CFG_W;
  localparam int GW   = PW + CW;
  localparam int CMPW = ((PW > CW) ? PW : CW) + 1;
  localparam logic [PW-1:0]   DEPTH_P = PW'(STORE_DEPTH);
  localparam logic [GW-1:0]   DEPTH_G = GW'(STORE_DEPTH);
  localparam logic [CMPW-1:0] DEPTH_C = CMPW'(STORE_DEPTH);
  localparam logic [lexbuf_pkg::CHAR_W:0] NSYM = (lexbuf_pkg::CHAR_W + 1)'(COUNTED_SYMBOLS);

  function automatic logic [PW-1:0] clamp_cap(input logic [CW-1:0] c);
    logic [PW-1:0] r;
    if (c == '0) begin
      r = PW'(1);
    end else if (CMPW'(c) > DEPTH_C) begin
      r = DEPTH_P;
    end else begin
      r = PW'(c);
    end
    return r;
  endfunction

  logic [1:0]    growth_mode;
  logic [CW-1:0] growth_inc;
  logic [PW-1:0] rd, wr, mark, cap;
  logic          end_seen, grew;

  logic [GW-1:0] grow_sum, grow_prod, grow_cap;
  logic          grow_ok, at_cap;
  logic          end_next, grew_next;

  assign cfg.ready = 1'b1;

  always_comb begin
    grow_sum  = GW'(cap) + GW'(growth_inc);
    grow_prod = GW'(cap) * GW'(growth_inc);
    grow_cap  = (growth_mode == lexbuf_pkg::GROW_MUL) ? grow_prod : grow_sum;
    grow_ok   = (growth_mode == lexbuf_pkg::GROW_ADD || growth_mode == lexbuf_pkg::GROW_MUL)
                && grow_cap <= DEPTH_G && grow_cap > GW'(wr);
    at_cap    = wr >= cap;

    rd_next   = rd;
    wr_next   = wr;
    mark_next = mark;
    cap_next  = cap;
    end_next  = end_seen;
    grew_next = grew;
    st        = '0;
    st.ok     = 1'b1;
    mem_we    = 1'b0;

    unique case (lexbuf_pkg::action_t'(action))
      lexbuf_pkg::ACT_APPEND: begin
        grew_next = 1'b0;
        if ((!at_cap || grow_ok) && wr < DEPTH_P) begin
          mem_we  = 1'b1;
          wr_next = wr + PW'(1);
          if (at_cap) begin
            cap_next  = grow_cap[PW-1:0];
            grew_next = 1'b1;
          end
          st.cnt_bump = {1'b0, ch} < NSYM;
        end else begin
          st.ok = 1'b0;
        end
      end
      lexbuf_pkg::ACT_READ: begin
        if (rd >= wr || rd >= DEPTH_P) begin
          end_next = 1'b1;
        end else begin
          end_next   = 1'b0;
          st.byte_rd = 1'b1;
          rd_next    = rd + PW'(1);
        end
      end
      lexbuf_pkg::ACT_MARK: begin
        if (target > wr) begin
          st.ok = 1'b0;
        end else begin
          mark_next = target;
        end
      end
      lexbuf_pkg::ACT_RETRACT: begin
        if (rd != '0) begin
          rd_next = rd - PW'(1);
        end
      end
      lexbuf_pkg::ACT_RESTORE: begin
        rd_next = mark;
      end
      lexbuf_pkg::ACT_REWIND: begin
        rd_next   = '0;
        mark_next = '0;
      end
      lexbuf_pkg::ACT_CLEAR: begin
        rd_next   = '0;
        wr_next   = '0;
        mark_next = '0;
        end_next  = 1'b0;
        grew_next = 1'b0;
      end
      lexbuf_pkg::ACT_QUERY: begin
        st.cnt_query = {1'b0, ch} < NSYM;
      end
      default: begin
      end
    endcase

    st.end_seen = end_next;
    st.grew     = grew_next;
    st.full     = wr_next == cap_next;
    st.empty    = wr_next == '0;
    mem_waddr   = wr[AW-1:0];
    mem_raddr   = rd[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      growth_mode <= lexbuf_pkg::RESET_GROWTH_MODE;
      growth_inc  <= lexbuf_pkg::RESET_GROWTH_INC;
      rd          <= '0;
      wr          <= '0;
      mark        <= '0;
      cap         <= clamp_cap(lexbuf_pkg::RESET_INIT_CAP);
      end_seen    <= 1'b0;
      grew        <= 1'b0;
    end else begin
      if (accept) begin
        rd       <= rd_next;
        wr       <= wr_next;
        mark     <= mark_next;
        cap      <= cap_next;
        end_seen <= end_next;
        grew     <= grew_next;
      end
      if (cfg.valid) begin
        unique case (cfg.index)
          lexbuf_pkg::REG_GROWTH_MODE: growth_mode <= cfg.data[1:0];
          lexbuf_pkg::REG_INIT_CAP: begin
            cap <= clamp_cap(cfg.data);
          end
          lexbuf_pkg::REG_GROWTH_INC: growth_inc <= cfg.data;
          default: begin
          end
        endcase
      end
    end
  end

endmodule

>>> rtl/lexbuf_tally.sv
module lexbuf_tally #(
  parameter int COUNTED_SYMBOLS = 128,
  localparam int SW = (COUNTED_SYMBOLS > 1) ? $clog2(COUNTED_SYMBOLS) : 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           look,
  input  logic [lexbuf_pkg::CHAR_W-1:0]  sym,
  input  logic                           commit,
  input  logic                           bump,
  input  logic                           query,
  output logic [lexbuf_pkg::COUNT_W-1:0] count
);

  localparam int NW = lexbuf_pkg::COUNT_W;

  logic [SW-1:0]          sym_q;
  logic [NW-1:0]          ram_q;
  logic [COUNTED_SYMBOLS-1:0] seen;
  logic                   fwd_valid;
  logic [SW-1:0]          fwd_addr;
  logic [NW-1:0]          fwd_data;
  logic [NW-1:0]          cur, bumped;
  logic                   wr_en;

  lexbuf_ram #(
    .WIDTH (NW),
    .DEPTH (COUNTED_SYMBOLS)
  ) u_counts (
    .clk   (clk),
    .we    (wr_en),
    .waddr (sym_q),
    .wdata (bumped),
    .re    (look),
    .raddr (sym[SW-1:0]),
    .rdata (ram_q)
  );

  // the latest write always matches memory contents, so it can be preferred
  always_comb begin
    if (fwd_valid && fwd_addr == sym_q) begin
      cur = fwd_data;
    end else if (seen[sym_q]) begin
      cur = ram_q;
    end else begin
      cur = '0;
    end
    bumped = (cur == '1) ? cur : cur + NW'(1);
    wr_en  = commit && bump;
    count  = query ? cur : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen      <= '0;
      fwd_valid <= 1'b0;
    end else if (wr_en) begin
      seen[sym_q] <= 1'b1;
      fwd_valid   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (look) begin
      sym_q <= sym[SW-1:0];
    end
    if (wr_en) begin
      fwd_addr <= sym_q;
      fwd_data <= bumped;
    end
  end

endmodule

>>> rtl/lexer_input_buffer_with_mark_core.sv
// pipeline: an accepted transaction passes the s2 register, then the result register
// throughput: one transaction per cycle unless results.ready stalls it, limited by one
// byte store access and one read-modify-write of the symbol counter memory per item
// reset: offsets, flags and symbol counts clear, registers return to their defaults
// and capacity reloads from the initial capacity; byte store contents are not cleared
module lexer_input_buffer_with_mark_core #(
  parameter int STORE_DEPTH = 4096,
  parameter int COUNTED_SYMBOLS = 128
) (
  input  logic           clk,
  input  logic           rst,
  lexbuf_in_if.sink      items,
  lexbuf_out_if.source   results,
  lexbuf_cfg_if.sink     cfg
);

  localparam int PW = $clog2(STORE_DEPTH + 1);
  localparam int AW = $clog2(STORE_DEPTH);

  logic              accept;
  logic              s2_valid, s2_adv;
  logic              out_valid;
  lexbuf_pkg::stat_t st, s2_st;
  logic [PW-1:0]     rd_next, wr_next, mark_next, cap_next;
  logic [PW-1:0]     s2_rd, s2_wr, s2_mark, s2_cap;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [lexbuf_pkg::CHAR_W-1:0]  store_q;
  logic [lexbuf_pkg::COUNT_W-1:0] count;

  assign s2_adv      = s2_valid && (!out_valid || results.ready);
  assign items.ready = !s2_valid || s2_adv;
  assign accept      = items.valid && items.ready;
  assign results.valid = out_valid;

  lexbuf_ctrl #(
    .STORE_DEPTH     (STORE_DEPTH),
    .COUNTED_SYMBOLS (COUNTED_SYMBOLS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .action    (items.action),
    .ch        (items.char_value),
    .target    (items.mark_target),
    .st        (st),
    .rd_next   (rd_next),
    .wr_next   (wr_next),
    .mark_next (mark_next),
    .cap_next  (cap_next),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_raddr (mem_raddr)
  );

  // store data is used only from reads below the write offset, never a same-cycle write
  lexbuf_ram #(
    .WIDTH (lexbuf_pkg::CHAR_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (accept && mem_we),
    .waddr (mem_waddr),
    .wdata (items.char_value),
    .re    (accept),
    .raddr (mem_raddr),
    .rdata (store_q)
  );

  lexbuf_tally #(
    .COUNTED_SYMBOLS (COUNTED_SYMBOLS)
  ) u_tally (
    .clk    (clk),
    .rst    (rst),
    .look   (accept),
    .sym    (items.char_value),
    .commit (s2_adv),
    .bump   (s2_st.cnt_bump),
    .query  (s2_st.cnt_query),
    .count  (count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s2_valid <= 1'b1;
      end else if (s2_adv) begin
        s2_valid <= 1'b0;
      end
      if (s2_adv) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_st   <= st;
      s2_rd   <= rd_next;
      s2_wr   <= wr_next;
      s2_mark <= mark_next;
      s2_cap  <= cap_next;
    end
    if (s2_adv) begin
      results.ok             <= s2_st.ok;
      results.char_out       <= s2_st.byte_rd ? store_q : '0;
      results.end_of_data    <= s2_st.end_seen;
      results.grew           <= s2_st.grew;
      results.full_res       <= s2_st.full;
      results.empty_res      <= s2_st.empty;
      results.read_position  <= s2_rd;
      results.write_position <= s2_wr;
      results.mark_position  <= s2_mark;
      results.capacity_now   <= s2_cap;
      results.symbol_count   <= count;
    end
  end

endmodule
